### design/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and codes for the fixed-partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

   // placement policy codes held in the fit_mode register
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_ALLOC = 1'b1;

   // register map
   localparam int          CSR_ADDR_BITS     = 2;
   localparam logic [1:0]  CSR_ADDR_FIT_MODE = 2'd0;

   // per-cycle control broadcast from the sequencer to every cell
   typedef struct packed {
      logic       scan_en;    // advance the candidate record one cell
      logic       load_en;    // write a partition size
      logic       commit_en;  // claim the chosen partition
      logic [1:0] fit_mode;
   } cell_ctl_type;

endpackage

### design/fpfa_cell.sv
// ----------------------------------------------------------------------------
// fpfa_cell
// One partition entry plus one stage of the candidate search chain.
// ----------------------------------------------------------------------------
module fpfa_cell
   import fpfa_pkg::*;
#(
   parameter int CELL_INDEX = 0,
   parameter int INDEX_BITS = 3,
   parameter int SIZE_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctl_type          ctl,
   input  logic [2:0]            load_index,
   input  logic [SIZE_BITS-1:0]  load_size,
   input  logic [INDEX_BITS-1:0] commit_index,
   input  logic [SIZE_BITS-1:0]  request,
   input  logic [7:0]            owner_tag,
   input  logic                  prev_found,
   input  logic [INDEX_BITS-1:0] prev_index,
   input  logic [SIZE_BITS-1:0]  prev_size,
   output logic                  next_found,
   output logic [INDEX_BITS-1:0] next_index,
   output logic [SIZE_BITS-1:0]  next_size
);

   logic [SIZE_BITS-1:0]  remaining_ff;
   logic                  occupied_ff;
   logic [7:0]            owner_ff;
   logic                  found_ff;
   logic [INDEX_BITS-1:0] index_ff;
   logic [SIZE_BITS-1:0]  size_ff;

   logic eligible;
   logic take;
   logic load_hit;
   logic commit_hit;

   assign eligible   = !occupied_ff && (remaining_ff >= request);
   assign load_hit   = ctl.load_en && (32'(load_index) == CELL_INDEX);
   assign commit_hit = ctl.commit_en && (commit_index == INDEX_BITS'(CELL_INDEX));

   // first eligible always wins; best/worst take later ones only on a strict compare
   always_comb begin
      take = 1'b0;
      if (eligible) begin
         if (!prev_found) begin
            take = 1'b1;
         end else if (ctl.fit_mode == FIT_BEST) begin
            take = remaining_ff < prev_size;
         end else if (ctl.fit_mode == FIT_WORST) begin
            take = remaining_ff > prev_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         occupied_ff  <= 1'b0;
      end else if (load_hit) begin
         remaining_ff <= load_size;
         occupied_ff  <= 1'b0;
      end else if (commit_hit) begin
         remaining_ff <= remaining_ff - request;
         occupied_ff  <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_hit) begin
         owner_ff <= owner_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl.scan_en) begin
         found_ff <= prev_found || take;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.scan_en) begin
         index_ff <= take ? INDEX_BITS'(CELL_INDEX) : prev_index;
         size_ff  <= take ? remaining_ff : prev_size;
      end
   end

   assign next_found = found_ff;
   assign next_index = index_ff;
   assign next_size  = size_ff;

endmodule

### design/fixed_partition_fit_allocator.sv
// A load's result is registered and appears in the cycle after its command transfer; an
//   allocation's result follows its scan states, the commit state and the result register.
// One load per cycle while idle; an allocation holds busy, taking no command, through its
//   scan and commit while the candidate record walks the cell chain one partition per cycle.
// Results cannot be stalled. Reset clears all partitions to size 0 and free, fit_mode to
//   first fit; owner tags are unknown until written.
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Fixed-partition allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator
   import fpfa_pkg::*;
#(
   parameter int PARTITION_COUNT = 8,
   parameter int SIZE_BITS       = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // command channel
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_kind,
   input  logic [2:0]               req_load_index,
   input  logic [15:0]              req_size_value,
   input  logic [7:0]               req_owner_tag,
   // result channel
   output logic                     rsp_valid,
   output logic                     rsp_granted,
   output logic [2:0]               rsp_slot_index,
   output logic [15:0]              rsp_leftover,
   // register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   localparam int INDEX_BITS = (PARTITION_COUNT > 1) ? $clog2(PARTITION_COUNT) : 1;
   localparam logic [INDEX_BITS-1:0] LAST_CELL = INDEX_BITS'(PARTITION_COUNT - 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   // ---------------------------------------------------------------------
   // Register port: single fit_mode register, zero wait states.
   // ---------------------------------------------------------------------
   logic [1:0] fit_mode_ff;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr == CSR_ADDR_FIT_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff <= FIT_FIRST;
      end else if (csr_write) begin
         fit_mode_ff <= pwdata[1:0];
      end
   end

   assign prdata = (paddr == CSR_ADDR_FIT_MODE) ? {30'd0, fit_mode_ff} : 32'd0;

   // ---------------------------------------------------------------------
   // Command intake. A load is written straight into its cell on the
   // transfer edge; an allocation latches its request and starts the scan.
   // ---------------------------------------------------------------------
   logic [1:0]            state_ff,  state_in;
   logic [INDEX_BITS-1:0] count_ff,  count_in;
   logic [SIZE_BITS-1:0]  request_ff;
   logic [7:0]            tag_ff;

   logic                  take_item;
   logic                  take_load;
   logic                  take_alloc;
   logic                  load_in_range;
   logic [SIZE_BITS-1:0]  req_size;

   assign busy          = (state_ff != ST_IDLE);
   assign take_item     = start && !busy;
   assign take_load     = take_item && (req_kind == KIND_LOAD);
   assign take_alloc    = take_item && (req_kind == KIND_ALLOC);
   assign load_in_range = 32'(req_load_index) < PARTITION_COUNT;
   // bits at and above SIZE_BITS are dropped; narrower ports zero-extend
   assign req_size      = SIZE_BITS'(req_size_value);

   always_ff @(posedge clock) begin
      if (take_alloc) begin
         request_ff <= req_size;
         tag_ff     <= req_owner_tag;
      end
   end

   // ---------------------------------------------------------------------
   // Cell chain. The candidate record (found, index, size) enters cell 0
   // empty and moves one cell per scan cycle; once it has passed every
   // cell in the scan state, the last cell holds the winner.
   // ---------------------------------------------------------------------
   cell_ctl_type          ctl;
   logic                  chain_found [PARTITION_COUNT+1];
   logic [INDEX_BITS-1:0] chain_index [PARTITION_COUNT+1];
   logic [SIZE_BITS-1:0]  chain_size  [PARTITION_COUNT+1];

   logic                  pick_found;
   logic [INDEX_BITS-1:0] pick_index;
   logic [SIZE_BITS-1:0]  pick_size;

   assign chain_found[0] = 1'b0;
   assign chain_index[0] = '0;
   assign chain_size[0]  = '0;

   assign pick_found = chain_found[PARTITION_COUNT];
   assign pick_index = chain_index[PARTITION_COUNT];
   assign pick_size  = chain_size[PARTITION_COUNT];

   always_comb begin
      ctl.scan_en   = (state_ff == ST_SCAN);
      ctl.load_en   = take_load;
      ctl.commit_en = (state_ff == ST_COMMIT) && pick_found;
      ctl.fit_mode  = fit_mode_ff;
   end

   for (genvar g = 0; g < PARTITION_COUNT; g++) begin : g_cell
      fpfa_cell #(
         .CELL_INDEX (g),
         .INDEX_BITS (INDEX_BITS),
         .SIZE_BITS  (SIZE_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .load_index   (req_load_index),
         .load_size    (req_size),
         .commit_index (pick_index),
         .request      (request_ff),
         .owner_tag    (tag_ff),
         .prev_found   (chain_found[g]),
         .prev_index   (chain_index[g]),
         .prev_size    (chain_size[g]),
         .next_found   (chain_found[g+1]),
         .next_index   (chain_index[g+1]),
         .next_size    (chain_size[g+1])
      );
   end

   // ---------------------------------------------------------------------
   // Sequencer: IDLE -> SCAN (until the count reaches the last cell) -> COMMIT -> IDLE.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            count_in = '0;
            if (take_alloc) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (count_ff == LAST_CELL) begin
               state_in = ST_COMMIT;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register: one strobe per item, for loads on the transfer edge,
   // for allocations at the commit edge.
   // ---------------------------------------------------------------------
   logic        valid_ff;
   logic        granted_ff;
   logic [2:0]  slot_ff;
   logic [15:0] leftover_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= take_load || (state_ff == ST_COMMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (take_load) begin
         granted_ff  <= 1'b0;
         slot_ff     <= req_load_index;
         leftover_ff <= load_in_range ? 16'(req_size) : 16'd0;
      end else if (state_ff == ST_COMMIT) begin
         granted_ff  <= pick_found;
         slot_ff     <= pick_found ? 3'(pick_index) : 3'd0;
         leftover_ff <= pick_found ? 16'(pick_size - request_ff) : 16'd0;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_granted    = granted_ff;
   assign rsp_slot_index = slot_ff;
   assign rsp_leftover   = leftover_ff;

endmodule
